// ----- hw/rtl/humidity_temp_frame_checker_core_macros.svh -----
// Assertion macros for the frame checker RTL, included by htfc_convert.
`ifndef HUMIDITY_TEMP_FRAME_CHECKER_CORE_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_CHECKER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define HTFC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame checker assertion failed");

// Next-cycle implication, disabled during reset.
`define HTFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame checker assertion failed");

`else

`define HTFC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define HTFC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/htfc_pkg.sv -----
// Shared types, constants and functions for the frame checker.
`timescale 1ns / 1ps

package htfc_pkg;

  // CRC-8 generator polynomial, no reflection, no final xor
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Conversion scale factors and offset
  localparam logic [16:0] HUM_SCALE   = 17'd100000;
  localparam logic [17:0] TEMP_SCALE  = 18'd165000;
  localparam logic [17:0] TEMP_OFFSET = 18'd40000;
  localparam logic [16:0] DIV_BASE    = 17'd65535;
  localparam logic [16:0] HUM_MAX     = 17'd100000;
  localparam logic [17:0] TEMP_Q_MAX  = 18'd165000;
  localparam logic signed [17:0] TEMP_MIN = -18'sd40000;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BUS_FAIL = 2'd1,
    ST_TEMP_BAD = 2'd2,
    ST_HUM_BAD  = 2'd3
  } status_t;

  // Position of the next byte within a reply
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CHK = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CHK = 3'd5
  } pos_t;

  // Finished frame handed to the converter
  typedef struct packed {
    status_t     status;
    logic [15:0] rh_raw;
    logic [15:0] t_raw;
  } frame_result_t;

  // Shift one byte through the CRC, MSB first
  function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(x / 65535): fold the high half back twice, then one compare
  function automatic logic [17:0] div_by_65535(input logic [33:0] x);
    logic [17:0] a;
    logic [15:0] b;
    logic [18:0] s;
    logic [2:0]  c;
    logic [16:0] e;
    logic [18:0] q;
    a = x[33:16];
    b = x[15:0];
    s = 19'(a) + 19'(b);
    c = s[18:16];
    e = 17'(s[15:0]) + 17'(c);
    q = 19'(a) + 19'(c) + 19'(e >= DIV_BASE);
    return q[17:0];
  endfunction

endpackage

// ----- hw/rtl/humidity_temp_frame_checker_core.sv -----
// Top level of the temperature and humidity sensor frame checker.
`timescale 1ns / 1ps

// Takes one reply byte per request, one request per cycle unless frame_stall
// is high: temperature high, low and CRC-8 (poly 0x31, init 0), then humidity
// high, low and CRC-8. The sixth byte, or a request with bus_failed set,
// yields one result with a status and the converted humidity (milli-percent)
// and temperature (milli-degrees C); rejected raw values count as zero, and
// humidity is kept only when the temperature check passed. A start mark
// restarts the frame. Byte tracking updates in the cycle a request is taken,
// so bytes flow at one per cycle unless stalled; the result of a closing byte
// passes the four-stage conversion pipeline (capture, multiply, divide by
// 65535, offset/output register). Up to four results can wait behind a stalled
// result port; frame_stall rises only when all four stages are full and held.

module humidity_temp_frame_checker_core
  import htfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               frame_valid,
  output logic               frame_stall,
  input  logic [7:0]         frame_byte,
  input  logic               frame_start,
  input  logic               bus_failed,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         status,
  output logic [16:0]        humidity_milli_percent,
  output logic signed [17:0] temperature_milli_c
);

  logic          accept;
  logic          emit_valid;
  logic          s1_ready;
  frame_result_t emit;

  // Take a byte request whenever the first conversion stage can move
  assign frame_stall = !s1_ready;
  assign accept      = frame_valid && s1_ready;

  htfc_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_byte  (frame_byte),
    .frame_start (frame_start),
    .bus_failed  (bus_failed),
    .emit_valid  (emit_valid),
    .emit        (emit)
  );

  htfc_convert u_convert (
    .clk                    (clk),
    .rst                    (rst),
    .emit_valid             (emit_valid),
    .emit                   (emit),
    .s1_ready               (s1_ready),
    .result_valid           (result_valid),
    .result_stall           (result_stall),
    .status                 (status),
    .humidity_milli_percent (humidity_milli_percent),
    .temperature_milli_c    (temperature_milli_c)
  );

endmodule

// ----- hw/rtl/htfc_frame.sv -----
// Byte tracker: CRC checks per data pair and frame result generation.
`timescale 1ns / 1ps

module htfc_frame
  import htfc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    frame_byte,
  input  logic          frame_start,
  input  logic          bus_failed,
  output logic          emit_valid,
  output frame_result_t emit
);

  pos_t        position, position_next, pos_eff;
  logic [7:0]  running_check, running_check_next;
  logic [7:0]  upper_byte, upper_byte_next;
  logic [15:0] t_raw_held, t_raw_held_next;
  logic [15:0] h_raw_held, h_raw_held_next;
  logic        t_accepted, t_accepted_next;

  // Start mark forces byte zero
  assign pos_eff = frame_start ? POS_T_HI : position;

  // Next position
  always_comb begin
    position_next = position;
    if (accept) begin
      if (bus_failed) begin
        position_next = POS_T_HI;
      end else begin
        case (pos_eff)
          POS_T_LO:  position_next = POS_T_CHK;
          POS_T_CHK: position_next = POS_H_HI;
          POS_H_HI:  position_next = POS_H_LO;
          POS_H_LO:  position_next = POS_H_CHK;
          POS_H_CHK: position_next = POS_T_HI;
          default:   position_next = POS_T_LO;
        endcase
      end
    end
  end

  // Check, data capture and result request
  always_comb begin
    running_check_next = running_check;
    upper_byte_next    = upper_byte;
    t_raw_held_next    = t_raw_held;
    h_raw_held_next    = h_raw_held;
    t_accepted_next    = t_accepted;
    emit_valid         = 1'b0;
    emit.status        = ST_OK;
    emit.rh_raw        = '0;
    emit.t_raw         = '0;
    if (accept) begin
      if (bus_failed) begin
        t_accepted_next = 1'b0;
        emit_valid      = 1'b1;
        emit.status     = ST_BUS_FAIL;
      end else begin
        case (pos_eff)
          POS_T_LO: begin
            running_check_next = crc8_add(running_check, frame_byte);
            t_raw_held_next    = {upper_byte, frame_byte};
          end
          POS_T_CHK: begin
            t_accepted_next    = (running_check == frame_byte);
            running_check_next = '0;
          end
          POS_H_HI: begin
            upper_byte_next    = frame_byte;
            running_check_next = crc8_add(8'h00, frame_byte);
          end
          POS_H_LO: begin
            running_check_next = crc8_add(running_check, frame_byte);
            h_raw_held_next    = {upper_byte, frame_byte};
          end
          POS_H_CHK: begin
            emit_valid = 1'b1;
            if (!t_accepted) begin
              emit.status = ST_TEMP_BAD;
            end else if (running_check != frame_byte) begin
              emit.status = ST_HUM_BAD;
              emit.t_raw  = t_raw_held;
            end else begin
              emit.status = ST_OK;
              emit.rh_raw = h_raw_held;
              emit.t_raw  = t_raw_held;
            end
            t_accepted_next    = 1'b0;
            running_check_next = '0;
          end
          default: begin
            upper_byte_next    = frame_byte;
            running_check_next = crc8_add(8'h00, frame_byte);
            t_accepted_next    = 1'b0;
          end
        endcase
      end
    end
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= POS_T_HI;
      running_check <= '0;
      upper_byte    <= '0;
      t_raw_held    <= '0;
      h_raw_held    <= '0;
      t_accepted    <= 1'b0;
    end else begin
      position      <= position_next;
      running_check <= running_check_next;
      upper_byte    <= upper_byte_next;
      t_raw_held    <= t_raw_held_next;
      h_raw_held    <= h_raw_held_next;
      t_accepted    <= t_accepted_next;
    end
  end

endmodule

// ----- hw/rtl/htfc_convert.sv -----
// Conversion pipeline: scale multiply, divide by 65535, offset, result register.
`timescale 1ns / 1ps
`include "humidity_temp_frame_checker_core_macros.svh"

module htfc_convert
  import htfc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                emit_valid,
  input  frame_result_t       emit,
  output logic                s1_ready,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [1:0]          status,
  output logic [16:0]         humidity_milli_percent,
  output logic signed [17:0]  temperature_milli_c
);

  logic        v1, v2, v3;
  status_t     st1, st2, st3, st_out;
  logic [15:0] rh1, t1;
  logic [32:0] ph;
  logic [33:0] pt;
  logic [16:0] qh;
  logic [17:0] qt;
  logic        out_ready, s3_ready, s2_ready;

  // Stage ready chain; a stage takes a new request when empty or draining
  assign out_ready = !result_valid || !result_stall;
  assign s3_ready  = !v3 || out_ready;
  assign s2_ready  = !v2 || s3_ready;
  assign s1_ready  = !v1 || s2_ready;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        v1 <= emit_valid;
      end
      if (s2_ready) begin
        v2 <= v1;
      end
      if (s3_ready) begin
        v3 <= v2;
      end
      if (out_ready) begin
        result_valid <= v3;
      end
    end
  end

  // Capture raw values, multiply, divide, offset
  always_ff @(posedge clk) begin
    if (s1_ready && emit_valid) begin
      st1 <= emit.status;
      rh1 <= emit.rh_raw;
      t1  <= emit.t_raw;
    end
    if (s2_ready && v1) begin
      st2 <= st1;
      ph  <= 33'(HUM_SCALE) * 33'(rh1);
      pt  <= 34'(TEMP_SCALE) * 34'(t1);
    end
    if (s3_ready && v2) begin
      st3 <= st2;
      qh  <= 17'(div_by_65535({1'b0, ph}));
      qt  <= div_by_65535(pt);
    end
    if (out_ready && v3) begin
      st_out                 <= st3;
      humidity_milli_percent <= qh;
      temperature_milli_c    <= $signed(qt - TEMP_OFFSET);
    end
  end

  assign status = st_out;

  // Full pipeline is the only cause of back-pressure on frame bytes
  `HTFC_ASSERT_IMPLY(a_stall_only_full, clk, rst, !s1_ready, v1 && v2 && v3 && result_valid)
  // Failed transfer carries zero raw values into the products
  `HTFC_ASSERT_IMPLY(a_fail_zero_prod, clk, rst, v2 && (st2 == ST_BUS_FAIL), (ph == '0) && (pt == '0))
  // Quotients stay within the scale
  `HTFC_ASSERT_IMPLY(a_quot_range, clk, rst, v3, (qh <= HUM_MAX) && (qt <= TEMP_Q_MAX))
  // Failed transfer reports the bottom of the temperature range
  `HTFC_ASSERT_IMPLY(a_fail_temp, clk, rst, result_valid && (st_out == ST_BUS_FAIL), temperature_milli_c == TEMP_MIN)

endmodule

// ----- tb/humidity_temp_frame_checker_core_tb.sv -----
// Self-checking testbench for the sensor reply frame checker core.
`timescale 1ns / 1ps

module humidity_temp_frame_checker_core_tb;
  import htfc_pkg::*;

  localparam int RANDOM_REQUESTS = 1450;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int MAX_PRINTED     = 100;

  // One converted reading as the result port should carry it
  typedef struct {
    status_t            st;
    logic [16:0]        hum;
    logic signed [17:0] temp;
  } reading_t;

  // Tracks the reply bytes and holds the readings still owed by the block
  class frame_scoreboard;
    pos_t        next_pos;
    logic [7:0]  crc_acc;
    logic [7:0]  hi_byte;
    logic [15:0] t_raw;
    logic        t_ok;
    logic [15:0] rh_raw;
    reading_t    owed[$];
    int          errors;

    function new();
      next_pos = POS_T_HI;
      crc_acc  = 8'h00;
      hi_byte  = 8'h00;
      t_raw    = 16'h0000;
      t_ok     = 1'b0;
      rh_raw   = 16'h0000;
      errors   = 0;
    endfunction

    // CRC-8, MSB first, no reflection
    static function logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      repeat (8) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
    endfunction

    static function logic [16:0] to_milli_percent(input logic [15:0] raw);
      longint unsigned prod;
      prod = HUM_SCALE;
      prod = prod * raw / DIV_BASE;
      return prod[16:0];
    endfunction

    static function logic signed [17:0] to_milli_c(input logic [15:0] raw);
      longint unsigned prod;
      logic [17:0]     q;
      prod = TEMP_SCALE;
      prod = prod * raw / DIV_BASE;
      q    = prod[17:0];
      return signed'(q - TEMP_OFFSET);
    endfunction

    function void owe(input status_t st, input logic [15:0] rh, input logic [15:0] t);
      reading_t r;
      r.st   = st;
      r.hum  = to_milli_percent(rh);
      r.temp = to_milli_c(t);
      owed.push_back(r);
    endfunction

    // Advance the byte tracker on an accepted request
    function void note_request(input logic [7:0] b, input logic s, input logic f);
      pos_t pos;
      if (f) begin
        next_pos = POS_T_HI;
        t_ok     = 1'b0;
        owe(ST_BUS_FAIL, 16'h0000, 16'h0000);
        return;
      end
      pos = s ? POS_T_HI : next_pos;
      case (pos)
        POS_T_LO: begin
          crc_acc  = crc_byte(crc_acc, b);
          t_raw    = {hi_byte, b};
          next_pos = POS_T_CHK;
        end
        POS_T_CHK: begin
          t_ok     = (crc_acc == b);
          crc_acc  = 8'h00;
          next_pos = POS_H_HI;
        end
        POS_H_HI: begin
          hi_byte  = b;
          crc_acc  = crc_byte(8'h00, b);
          next_pos = POS_H_LO;
        end
        POS_H_LO: begin
          crc_acc  = crc_byte(crc_acc, b);
          rh_raw   = {hi_byte, b};
          next_pos = POS_H_CHK;
        end
        POS_H_CHK: begin
          if (!t_ok) begin
            owe(ST_TEMP_BAD, 16'h0000, 16'h0000);
          end else if (crc_acc != b) begin
            owe(ST_HUM_BAD, 16'h0000, t_raw);
          end else begin
            owe(ST_OK, rh_raw, t_raw);
          end
          next_pos = POS_T_HI;
          t_ok     = 1'b0;
          crc_acc  = 8'h00;
        end
        default: begin
          hi_byte  = b;
          crc_acc  = crc_byte(8'h00, b);
          t_ok     = 1'b0;
          next_pos = POS_T_LO;
        end
      endcase
    endfunction

    task report(input string what);
      if (errors < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Compare a taken result against the oldest owed reading
    task check_result(input logic [1:0] st, input logic [16:0] hum,
                      input logic signed [17:0] temp);
      reading_t r;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result status=%0d hum=%0d temp=%0d", st, hum, temp));
        return;
      end
      r = owed.pop_front();
      if (st !== r.st) report($sformatf("status %0d, want %0d", st, r.st));
      if (hum !== r.hum) report($sformatf("humidity %0d, want %0d", hum, r.hum));
      if (temp !== r.temp) report($sformatf("temperature %0d, want %0d", temp, r.temp));
    endtask

    function int outstanding();
      return owed.size();
    endfunction
  endclass

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               frame_valid  = 1'b0;
  logic               frame_stall;
  logic [7:0]         frame_byte   = 8'h00;
  logic               frame_start  = 1'b0;
  logic               bus_failed   = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [1:0]         status;
  logic [16:0]        humidity_milli_percent;
  logic signed [17:0] temperature_milli_c;

  frame_scoreboard sb = new();
  int idle_pct    = 0;
  int stall_pct   = 0;
  int sent        = 0;
  int cycle_count = 0;

  humidity_temp_frame_checker_core DUT (
    .clk                    (clk),
    .rst                    (rst),
    .frame_valid            (frame_valid),
    .frame_stall            (frame_stall),
    .frame_byte             (frame_byte),
    .frame_start            (frame_start),
    .bus_failed             (bus_failed),
    .result_valid           (result_valid),
    .result_stall           (result_stall),
    .status                 (status),
    .humidity_milli_percent (humidity_milli_percent),
    .temperature_milli_c    (temperature_milli_c)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result port at random
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Sample a result mid-cycle; it is taken at the next rising edge
  always @(negedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_result(status, humidity_milli_percent, temperature_milli_c);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one request, with random idle cycles ahead of it, and hold it until taken
  task automatic send_request(input logic [7:0] b, input logic s, input logic f);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      frame_valid <= 1'b0;
      @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame_byte  <= b;
    frame_start <= s;
    bus_failed  <= f;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !frame_stall;
      @(posedge clk);
    end
    sb.note_request(b, s, f);
    sent++;
  endtask

  // Send a full six-byte reply, optionally with either or both check bytes corrupted
  task automatic send_reply(input logic [15:0] t, input logic [15:0] rh,
                            input bit bad_t, input bit bad_h, input logic mark);
    logic [7:0] tc;
    logic [7:0] hc;
    tc = frame_scoreboard::crc_byte(frame_scoreboard::crc_byte(8'h00, t[15:8]), t[7:0]);
    hc = frame_scoreboard::crc_byte(frame_scoreboard::crc_byte(8'h00, rh[15:8]), rh[7:0]);
    if (bad_t) tc = tc ^ 8'($urandom_range(255, 1));
    if (bad_h) hc = hc ^ 8'($urandom_range(255, 1));
    send_request(t[15:8], mark, 1'b0);
    send_request(t[7:0], 1'b0, 1'b0);
    send_request(tc, 1'b0, 1'b0);
    send_request(rh[15:8], 1'b0, 1'b0);
    send_request(rh[7:0], 1'b0, 1'b0);
    send_request(hc, 1'b0, 1'b0);
  endtask

  // Hold off new requests until every owed result has come back
  task automatic drain();
    frame_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    int phase;
    int goal;
    int kind;
    int n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: raw extremes, both bad checks, restarts and bus failures
    send_reply(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1);
    send_reply(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b1);
    send_request(8'hA5, 1'b1, 1'b0);
    send_request(8'h5A, 1'b0, 1'b0);
    send_reply(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1);
    send_reply(16'h1234, 16'hABCD, 1'b0, 1'b1, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'hFF, 1'b1, 1'b1);
    send_request(8'h00, 1'b0, 1'b1);
    drain();

    // Random: mostly well-formed replies, the rest partial replies, bus failures and noise
    goal = sent;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      goal = goal + RANDOM_REQUESTS / 4;
      while (sent < goal) begin
        kind = $urandom_range(99);
        if (kind < 70) begin
          send_reply(16'($urandom), 16'($urandom), $urandom_range(9) == 0,
                     $urandom_range(9) == 0, $urandom_range(9) != 0);
        end else if (kind < 80) begin
          n = $urandom_range(5, 1);
          send_request(8'($urandom), 1'b1, 1'b0);
          repeat (n - 1) send_request(8'($urandom), 1'b0, 1'b0);
        end else if (kind < 90) begin
          send_request(8'($urandom), 1'($urandom), 1'b1);
        end else begin
          send_request(8'($urandom), 1'($urandom), 1'b0);
        end
      end
      drain();
    end

    idle_pct  = 0;
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
